[rtl/core/bert_pkg.sv]
// Package for the bit error rate tester: default sizes, item mode codes and
// the status bundle passed from the divider to the top level.
// No dependencies.
`timescale 1ns / 1ps

package bert_pkg;

  localparam int unsigned CountBitsDef     = 32;
  localparam int unsigned RatioFracBitsDef = 16;
  localparam int unsigned ModeW            = 2;
  localparam int unsigned ValueW           = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_RECORD = 2'd0,
    MODE_START  = 2'd1,
    MODE_STOP   = 2'd2
  } bert_mode_e;

  typedef struct packed {
    logic done;
  } div_status_t;

endpackage

[rtl/core/bert_cnt.sv]
// Arm flag and the two saturating counters of the tester.
// Depends on bert_pkg for the mode codes.
`timescale 1ns / 1ps

module bert_cnt import bert_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [ModeW-1:0]      mode_i,
  input  logic [ValueW-1:0]     expected_value_i,
  input  logic [ValueW-1:0]     received_value_i,
  output logic                  armed_o,
  output logic [COUNT_BITS-1:0] errors_o,
  output logic [COUNT_BITS-1:0] errors_d_o,
  output logic [COUNT_BITS-1:0] total_o,
  output logic [COUNT_BITS-1:0] total_d_o
);

  logic                  armed_q, armed_d;
  logic [COUNT_BITS-1:0] errors_q, errors_d;
  logic [COUNT_BITS-1:0] total_q, total_d;

  always_comb begin
    armed_d  = armed_q;
    errors_d = errors_q;
    total_d  = total_q;
    if (accept_i) begin
      case (mode_i)
        MODE_START: begin
          armed_d  = 1'b1;
          errors_d = '0;
          total_d  = '0;
        end
        MODE_STOP: begin
          armed_d = 1'b0;
        end
        MODE_RECORD: begin
          if (armed_q) begin
            if (!(&total_q)) begin
              total_d = total_q + COUNT_BITS'(1);
            end
            if ((expected_value_i != received_value_i) && !(&errors_q)) begin
              errors_d = errors_q + COUNT_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q  <= 1'b0;
      errors_q <= '0;
      total_q  <= '0;
    end else begin
      armed_q  <= armed_d;
      errors_q <= errors_d;
      total_q  <= total_d;
    end
  end

  assign armed_o    = armed_q;
  assign errors_o   = errors_q;
  assign errors_d_o = errors_d;
  assign total_o    = total_q;
  assign total_d_o  = total_d;

endmodule

[rtl/core/bert_div.sv]
// Restoring divider, one quotient bit a cycle, for the error ratio.
// Depends on bert_pkg for the status bundle.
`timescale 1ns / 1ps

module bert_div import bert_pkg::*; #(
  parameter int unsigned COUNT_BITS = CountBitsDef,
  parameter int unsigned FRAC_BITS  = RatioFracBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [COUNT_BITS-1:0] num_i,
  input  logic [COUNT_BITS-1:0] den_i,
  output div_status_t           status_o,
  output logic [FRAC_BITS:0]    quot_o
);

  localparam int unsigned CntW = $clog2(FRAC_BITS + 1);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_e;

  div_state_e            state_q;
  logic [COUNT_BITS:0]   rem_q;
  logic [COUNT_BITS-1:0] den_q;
  logic [FRAC_BITS:0]    quot_q;
  logic [CntW-1:0]       cnt_q;
  logic                  zero_q;
  logic                  done_q;

  logic                  ge;
  logic [COUNT_BITS-1:0] diff;
  logic [COUNT_BITS-1:0] kept;

  // The remainder before its shift always stays below the divisor, so the
  // difference fits the counter width whenever it is kept.
  assign ge   = rem_q >= {1'b0, den_q};
  assign diff = rem_q[COUNT_BITS-1:0] - den_q;
  assign kept = ge ? diff : rem_q[COUNT_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      rem_q   <= '0;
      den_q   <= '0;
      quot_q  <= '0;
      cnt_q   <= '0;
      zero_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            rem_q   <= {1'b0, num_i};
            den_q   <= den_i;
            zero_q  <= (den_i == '0);
            quot_q  <= '0;
            cnt_q   <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          quot_q <= {quot_q[FRAC_BITS-1:0], ge};
          rem_q  <= {kept, 1'b0};
          cnt_q  <= cnt_q + CntW'(1);
          if (cnt_q == CntW'(FRAC_BITS)) begin
            state_q <= D_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

  assign status_o.done = done_q;
  assign quot_o        = zero_q ? '0 : quot_q;

endmodule

[rtl/core/bit_error_rate_tester.sv]
// Bit error rate tester: one word in, one result word out. A new word is only
// accepted once the result of the last has gone into the output register, so
// the pace is set by the restoring divider that produces one ratio bit a cycle.
// The result is loaded into the output register once the divider is done, if
// the output is not stalled. Asynchronous active-low reset disarms the test and
// clears both counters and the output register.
`timescale 1ns / 1ps

module bit_error_rate_tester import bert_pkg::*; #(
  parameter int unsigned COUNT_BITS      = CountBitsDef,
  parameter int unsigned RATIO_FRAC_BITS = RatioFracBitsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ModeW-1:0]           mode_i,
  input  logic [ValueW-1:0]          expected_value_i,
  input  logic [ValueW-1:0]          received_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       test_armed_o,
  output logic [COUNT_BITS-1:0]      error_count_o,
  output logic [COUNT_BITS-1:0]      total_count_o,
  output logic [RATIO_FRAC_BITS:0]   error_ratio_o
);

  // The sequencer walks each word through three phases. In idle it takes a
  // new word, updates the counters at that edge and starts the divider on the
  // updated counts. It then waits for the divider, and once the quotient is
  // ready it moves the whole result into the output register, or holds it
  // until that register is free.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } seq_state_e;

  seq_state_e                 state_q;
  logic                       out_valid_q;
  logic                       out_armed_q;
  logic [COUNT_BITS-1:0]      out_errors_q;
  logic [COUNT_BITS-1:0]      out_total_q;
  logic [RATIO_FRAC_BITS:0]   out_ratio_q;

  logic                       accept;
  logic                       out_free;
  logic                       load;

  logic                       armed;
  logic [COUNT_BITS-1:0]      errors, errors_d;
  logic [COUNT_BITS-1:0]      total, total_d;
  div_status_t                div_status;
  logic [RATIO_FRAC_BITS:0]   quot;

  // A new word is only taken in idle. The output register may still be
  // holding the previous result, since it keeps its own copy of the counts.
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign load       = out_free &&
                      (((state_q == ST_DIV) && div_status.done) || (state_q == ST_HOLD));

  bert_cnt #(
    .COUNT_BITS (COUNT_BITS)
  ) u_cnt (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .mode_i           (mode_i),
    .expected_value_i (expected_value_i),
    .received_value_i (received_value_i),
    .armed_o          (armed),
    .errors_o         (errors),
    .errors_d_o       (errors_d),
    .total_o          (total),
    .total_d_o        (total_d)
  );

  // The divider samples the counts as they will be after this word, so the
  // division starts at the very edge that accepts the word. The error count
  // never exceeds the total, so the quotient fits one integer bit.
  bert_div #(
    .COUNT_BITS (COUNT_BITS),
    .FRAC_BITS  (RATIO_FRAC_BITS)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (accept),
    .num_i    (errors_d),
    .den_i    (total_d),
    .status_o (div_status),
    .quot_o   (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      out_armed_q  <= 1'b0;
      out_errors_q <= '0;
      out_total_q  <= '0;
      out_ratio_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_status.done) begin
            state_q <= out_free ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase

      // The counters cannot change before the next word is accepted, so they
      // are still those of this word when the result is loaded.
      if (load) begin
        out_valid_q  <= 1'b1;
        out_armed_q  <= armed;
        out_errors_q <= errors;
        out_total_q  <= total;
        out_ratio_q  <= quot;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The result is driven straight from the output register.
  assign out_valid_o   = out_valid_q;
  assign test_armed_o  = out_armed_q;
  assign error_count_o = out_errors_q;
  assign total_count_o = out_total_q;
  assign error_ratio_o = out_ratio_q;

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the bit error rate tester: directed and random
// sessions against an in-line predictor of the arm flag, counts and ratio.
// Depends on bert_pkg and bit_error_rate_tester.
`timescale 1ns / 1ps

module tb;
  import bert_pkg::*;

  // Mode 3 carries no meaning; the block must only report on it.
  localparam logic [ModeW-1:0] MODE_UNUSED = 2'd3;

  localparam int unsigned      HALF_PERIOD    = 2;
  localparam int unsigned      RESET_CYCLES   = 9;
  localparam int unsigned      WORD_TARGET    = 850;
  localparam int unsigned      HOLDOFF_CYCLES = 400;
  // Idle limit: the long hold-off plus a full divide, taken several times over.
  localparam int unsigned      IDLE_LIMIT     = 4000;
  localparam int unsigned      DRAIN_CYCLES   = RatioFracBitsDef + 8;
  localparam logic [CountBitsDef-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                        armed;
    logic [CountBitsDef-1:0]     errors;
    logic [CountBitsDef-1:0]     total;
    logic [RatioFracBitsDef:0]   ratio;
  } tally_report_t;

  logic                      clk;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [ModeW-1:0]          mode;
  logic [ValueW-1:0]         tx_value;
  logic [ValueW-1:0]         rx_value;
  logic                      out_valid;
  logic                      out_stall;
  logic                      armed_seen;
  logic [CountBitsDef-1:0]   errors_seen;
  logic [CountBitsDef-1:0]   total_seen;
  logic [RatioFracBitsDef:0] ratio_seen;

  // Predictor state: a private copy of the arm flag and both tallies.
  logic                      link_armed;
  logic [CountBitsDef-1:0]   err_tally;
  logic [CountBitsDef-1:0]   cmp_tally;

  tally_report_t             report_q[$];

  int unsigned               mismatches;
  int unsigned               words_sent;
  int unsigned               reports_checked;
  int unsigned               sessions_run;
  int unsigned               full_scale_seen;
  logic [CountBitsDef-1:0]   largest_total;
  int unsigned               idle_cycles;

  // Sender burst shaping and the receiver's stall pattern.
  bit                        sender_gaps_on;
  int unsigned               burst_left;
  bit                        holdoff_req;
  int unsigned               holdoff_left;
  int unsigned               stall_style;
  int unsigned               style_left;
  int unsigned               phase_count;

  bit_error_rate_tester #(
    .COUNT_BITS     (CountBitsDef),
    .RATIO_FRAC_BITS(RatioFracBitsDef)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .mode_i          (mode),
    .expected_value_i(tx_value),
    .received_value_i(rx_value),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .test_armed_o    (armed_seen),
    .error_count_o   (errors_seen),
    .total_count_o   (total_seen),
    .error_ratio_o   (ratio_seen)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // A random decision value over the whole field range.
  function automatic logic [ValueW-1:0] rand_byte();
    return ValueW'($urandom_range(0, 255));
  endfunction

  // Applies one accepted word to the private state and returns the report
  // the block should give for it. The ratio is an exact floored quotient of
  // the error tally scaled by 2^16 over the comparison tally, so an all-error
  // session reads as full scale (one integer bit set).
  function automatic tally_report_t predict_report(input logic [ModeW-1:0]  op,
                                                   input logic [ValueW-1:0] tx,
                                                   input logic [ValueW-1:0] rx);
    tally_report_t    rep;
    longint unsigned  scaled;
    case (op)
      MODE_START: begin
        link_armed = 1'b1;
        err_tally  = '0;
        cmp_tally  = '0;
      end
      MODE_STOP: begin
        link_armed = 1'b0;
      end
      MODE_RECORD: begin
        // A record only counts while the test is armed; both tallies hold
        // at their maximum rather than wrapping.
        if (link_armed) begin
          if (cmp_tally != COUNT_MAX) cmp_tally = cmp_tally + CountBitsDef'(1);
          if (tx != rx && err_tally != COUNT_MAX) err_tally = err_tally + CountBitsDef'(1);
        end
      end
      default: begin
        // The unused mode leaves everything untouched.
      end
    endcase
    rep.armed  = link_armed;
    rep.errors = err_tally;
    rep.total  = cmp_tally;
    if (cmp_tally == '0) begin
      rep.ratio = '0;
    end else begin
      scaled    = err_tally;
      scaled    = (scaled << RatioFracBitsDef) / cmp_tally;
      rep.ratio = scaled[RatioFracBitsDef:0];
    end
    return rep;
  endfunction

  // Offers one word and waits for the handshake. In gap mode the sender
  // works in bursts: when a burst runs out, valid drops for a random number
  // of cycles with junk on the payload, then a new burst starts. Valid is
  // never lowered and raised in the same step.
  task automatic send_word(input logic [ModeW-1:0]  op,
                           input logic [ValueW-1:0] tx,
                           input logic [ValueW-1:0] rx);
    int unsigned gap;
    if (sender_gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      in_valid  <= 1'b0;
      mode      <= ModeW'($urandom_range(0, 3));
      tx_value  <= rand_byte();
      rx_value  <= rand_byte();
      repeat (gap) @(negedge clk);
    end
    if (burst_left != 0) burst_left--;
    in_valid <= 1'b1;
    mode     <= op;
    tx_value <= tx;
    rx_value <= rx;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    report_q.push_back(predict_report(op, tx, rx));
    words_sent++;
    if (cmp_tally > largest_total) largest_total = cmp_tally;
    @(negedge clk);
  endtask

  task automatic pause_sender(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // One armed comparison; a mismatch flips a random non-empty set of bits.
  task automatic record_decision(input int unsigned err_pct);
    logic [ValueW-1:0] tx;
    logic [ValueW-1:0] flips;
    tx    = rand_byte();
    flips = (err_pct > $urandom_range(0, 99)) ? ValueW'($urandom_range(1, 255)) : '0;
    send_word(MODE_RECORD, tx, tx ^ flips);
  endtask

  // With the test disarmed nothing may count, yet every word still reports.
  task automatic test_disarmed_reporting();
    send_word(MODE_RECORD, 8'h00, 8'hFF);
    send_word(MODE_STOP,   8'hFF, 8'h00);
    send_word(MODE_UNUSED, 8'hA5, 8'h5A);
    send_word(MODE_RECORD, 8'hFF, 8'hFF);
  endtask

  // Field extremes, every mode, a restart while armed, full-scale and
  // fractional ratios, and records after a stop.
  task automatic test_session_basics();
    send_word(MODE_START,  8'h00, 8'h00);
    send_word(MODE_RECORD, 8'h00, 8'h00);
    send_word(MODE_RECORD, 8'hFF, 8'hFF);
    send_word(MODE_RECORD, 8'hFF, 8'h00);
    send_word(MODE_RECORD, 8'h00, 8'hFF);
    send_word(MODE_RECORD, 8'h55, 8'hAA);
    send_word(MODE_UNUSED, 8'hFF, 8'h00);
    send_word(MODE_START,  8'hFF, 8'hFF);
    send_word(MODE_RECORD, 8'hA5, 8'h5A);
    send_word(MODE_RECORD, 8'h3C, 8'h3C);
    send_word(MODE_RECORD, 8'h0F, 8'h0F);
    send_word(MODE_STOP,   8'h00, 8'h00);
    send_word(MODE_RECORD, 8'h12, 8'h34);
    send_word(MODE_STOP,   8'h00, 8'h00);
    send_word(MODE_START,  8'h00, 8'h00);
    send_word(MODE_RECORD, 8'h80, 8'h80);
    send_word(MODE_RECORD, 8'h01, 8'h00);
    send_word(MODE_STOP,   8'h00, 8'h00);
  endtask

  // The receiver holds off for a long stretch while the sender keeps
  // offering back to back, so the block fills and stalls its input.
  task automatic test_receiver_holdoff();
    bit saved_gaps;
    saved_gaps     = sender_gaps_on;
    sender_gaps_on = 1'b0;
    pause_sender(1);
    @(posedge clk);
    holdoff_req = 1'b1;
    @(negedge clk);
    send_word(MODE_START, rand_byte(), rand_byte());
    repeat (5) record_decision(50);
    sender_gaps_on = saved_gaps;
  endtask

  // Mostly well-formed sessions (start, a run of records at a chosen error
  // rate, usually a stop) with noise in between: stray stops, unused modes
  // and records while disarmed. A session left armed is restarted by the
  // next one. A few sessions run long to push the tallies higher.
  task automatic test_random_sessions();
    int unsigned err_pct;
    int unsigned run_len;
    int unsigned pick;
    while (words_sent < WORD_TARGET) begin
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          pick = $urandom_range(0, 2);
          if (pick == 0) send_word(MODE_UNUSED, rand_byte(), rand_byte());
          else if (pick == 1) send_word(MODE_STOP, rand_byte(), rand_byte());
          else send_word(MODE_RECORD, rand_byte(), rand_byte());
        end
      end
      pick    = $urandom_range(0, 19);
      err_pct = (pick < 3) ? 0 : (pick < 6) ? 100 : $urandom_range(1, 99);
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 40);
      send_word(MODE_START, rand_byte(), rand_byte());
      sessions_run++;
      repeat (run_len) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) send_word(MODE_UNUSED, rand_byte(), rand_byte());
        else if (pick == 1) send_word(MODE_START, rand_byte(), rand_byte());
        else record_decision(err_pct);
      end
      if ($urandom_range(0, 9) < 7) begin
        send_word(MODE_STOP, rand_byte(), rand_byte());
      end
    end
  endtask

  // Receiver: picks a stall style for a random stretch (never, light, heavy
  // or periodic) and honours a hold-off request by counting it down here.
  always @(negedge clk) begin
    if (holdoff_req) begin
      holdoff_left = HOLDOFF_CYCLES;
      holdoff_req  = 1'b0;
    end
    if (style_left == 0) begin
      stall_style = $urandom_range(0, 3);
      style_left  = $urandom_range(40, 200);
    end
    style_left--;
    phase_count++;
    if (holdoff_left != 0) begin
      holdoff_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 30);
        2:       out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= ((phase_count % 7) < 3);
      endcase
    end
  end

  // Checks every accepted report against the oldest prediction, field by
  // field. A report with nothing predicted is a failure of its own.
  always @(posedge clk) begin
    tally_report_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (report_q.size() == 0) begin
        $display("%0t: unexpected report armed=%0b errors=%0d total=%0d ratio=%0d",
                 $time, armed_seen, errors_seen, total_seen, ratio_seen);
        mismatches++;
      end else begin
        want = report_q.pop_front();
        reports_checked++;
        if (want.ratio == (1 << RatioFracBitsDef)) full_scale_seen++;
        if (armed_seen !== want.armed) begin
          $display("%0t: test_armed expected %0b, got %0b", $time, want.armed, armed_seen);
          mismatches++;
        end
        if (errors_seen !== want.errors) begin
          $display("%0t: error_count expected %0d, got %0d", $time, want.errors, errors_seen);
          mismatches++;
        end
        if (total_seen !== want.total) begin
          $display("%0t: total_count expected %0d, got %0d", $time, want.total, total_seen);
          mismatches++;
        end
        if (ratio_seen !== want.ratio) begin
          $display("%0t: error_ratio expected %0d, got %0d", $time, want.ratio, ratio_seen);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on either side for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: timeout, no word accepted for %0d cycles, %0d reports outstanding",
                 $time, IDLE_LIMIT, report_q.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    mode            = MODE_RECORD;
    tx_value        = '0;
    rx_value        = '0;
    out_stall       = 1'b0;
    link_armed      = 1'b0;
    err_tally       = '0;
    cmp_tally       = '0;
    mismatches      = 0;
    words_sent      = 0;
    reports_checked = 0;
    sessions_run    = 0;
    full_scale_seen = 0;
    largest_total   = '0;
    idle_cycles     = 0;
    sender_gaps_on  = 1'b1;
    burst_left      = 0;
    holdoff_req     = 1'b0;
    holdoff_left    = 0;
    stall_style     = 0;
    style_left      = 0;
    phase_count     = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_disarmed_reporting();
    test_session_basics();
    test_receiver_holdoff();
    test_random_sessions();

    // Drain: wait for every report, then a little longer for strays.
    pause_sender(1);
    while (report_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d words over %0d random sessions plus directed cases and a hold-off,",
             words_sent, sessions_run);
    $display("with %0d reports checked, top count %0d, %0d full-scale ratios.",
             reports_checked, largest_total, full_scale_seen);
    if (mismatches == 0 && report_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[bit_error_rate_tester.f]
rtl/core/bert_pkg.sv
rtl/core/bert_cnt.sv
rtl/core/bert_div.sv
rtl/core/bit_error_rate_tester.sv
tb/sv/tb.sv
